// File: rtl/stl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    localparam int LINE_BITS    = 24;
    localparam int LENGTH_BITS  = 16;
    localparam int DEPTH_BITS   = 16;
    localparam int RES_MAX      = 4;
    localparam int RES_IDX_BITS = $clog2(RES_MAX);
    localparam int RES_CNT_BITS = $clog2(RES_MAX + 1);
    localparam int OP_SLOTS     = 4;
    localparam int WORD_OPS     = 3;
    localparam int REC_RAW_BITS = 8 + 3 + LENGTH_BITS + LINE_BITS + 3 + LINE_BITS + DEPTH_BITS;
    localparam int M_DATA_BITS  = ((REC_RAW_BITS + 7) / 8) * 8;

    typedef logic [LINE_BITS-1:0]   t_line;
    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [DEPTH_BITS-1:0]  t_depth;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        MODE_READY,
        MODE_COMMENT,
        MODE_BLOCK,
        MODE_WORD,
        MODE_QUOTE,
        MODE_VAR,
        MODE_SLASH
    } t_mode;

    typedef enum logic [1:0] {
        REC_LEXEME,
        REC_TOKEN,
        REC_END
    } t_rec_kind;

    typedef enum logic [2:0] {
        TOK_NEWLINE,
        TOK_OPEN,
        TOK_CLOSE,
        TOK_COLON,
        TOK_VAR,
        TOK_QUOTED,
        TOK_WORD
    } t_tok;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_UNMATCHED,
        ERR_QUOTE,
        ERR_ONE_OPEN,
        ERR_MANY_OPEN
    } t_err;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EMIT,
        OP_START,
        OP_ADD,
        OP_TOKEN,
        OP_NLTOK
    } t_op_code;

    typedef struct packed {
        t_op_code   code;
        logic [7:0] b;
    } t_op;

    typedef struct packed {
        t_rec_kind  kind;
        logic [7:0] lex;
        t_tok       tok;
        t_len       len;
        t_line      line;
        t_err       err;
        t_line      err_line;
        t_depth     open;
    } t_rec;

    function automatic logic is_nl(logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic t_op mk_op(t_op_code code, logic [7:0] b);
        t_op o;
        o.code = code;
        o.b    = b;
        return o;
    endfunction

    function automatic t_tok classify(t_len n, logic [7:0] f, logic [7:0] l);
        logic one;
        one = (n == t_len'(1));
        if (one && is_nl(f)) return TOK_NEWLINE;
        if (one && f == CH_LBRACE) return TOK_OPEN;
        if (one && f == CH_RBRACE) return TOK_CLOSE;
        if (one && f == CH_COLON) return TOK_COLON;
        if (n > t_len'(1) && f == CH_DOLLAR) return TOK_VAR;
        if (n > t_len'(1) && f == CH_QUOTE && l == CH_QUOTE) return TOK_QUOTED;
        return TOK_WORD;
    endfunction

    function automatic t_rec rec_lex(logic [7:0] b);
        t_rec r;
        r      = '0;
        r.kind = REC_LEXEME;
        r.lex  = b;
        return r;
    endfunction

    function automatic t_rec rec_tok(t_tok k, t_len n, t_line line);
        t_rec r;
        r      = '0;
        r.kind = REC_TOKEN;
        r.tok  = k;
        r.len  = n;
        r.line = line;
        return r;
    endfunction

    function automatic t_rec rec_end(t_err e, t_line line, t_depth open);
        t_rec r;
        r          = '0;
        r.kind     = REC_END;
        r.err      = e;
        r.err_line = line;
        r.open     = open;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/script_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// s (in)    in   i_s_tvalid/o_s_tready  i_s_tdata byte, i_s_tuser finish flag
// m (out)   out  o_m_tvalid/i_m_tready  o_m_tdata record, o_m_tuser kind, o_m_tlast
//
// One input transaction is taken per cycle while the output is not stalled and each
// item yields at most one record. An item yielding two to four records holds
// the input until its last record is taken: the four-entry result buffer drains one
// record per cycle while the output is ready and is refilled on the cycle it empties.
// Reset is synchronous, active low; it clears the lexer state and empties the buffer.
// Output stalls back up into the input only once the buffer holds undelivered records.

module script_token_lexer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output      logic                             o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // byte_value
    input  wire logic                             i_s_tuser,  // operation
    output      logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    // lexeme_byte, token_kind, token_length, token_line, error_code, error_line,
    // open_braces, zero fill
    output      logic [stl_pkg::M_DATA_BITS-1:0]  o_m_tdata,
    output      logic [1:0]                       o_m_tuser,  // record_kind
    output      logic                             o_m_tlast   // last_of_run
);

    stl_pkg::t_mode    r_mode,   n_mode;
    logic [7:0]        r_prev,   n_prev;
    stl_pkg::t_line    r_line,   n_line;
    stl_pkg::t_line    r_qline,  n_qline;
    stl_pkg::t_line    r_bline,  n_bline;
    stl_pkg::t_depth   r_depth,  n_depth;
    stl_pkg::t_len     r_len,    n_len;
    logic [7:0]        r_first,  n_first;
    logic [7:0]        r_last,   n_last;
    logic              r_pnl,    n_pnl;
    stl_pkg::t_err     r_sticky, n_sticky;
    stl_pkg::t_line    r_sline,  n_sline;

    stl_pkg::t_rec     r_res [stl_pkg::RES_MAX];
    stl_pkg::t_rec     n_res [stl_pkg::RES_MAX];
    logic [stl_pkg::RES_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [stl_pkg::RES_IDX_BITS-1:0] r_rd;

    stl_pkg::t_len     d_len;
    logic [7:0]        d_first;
    logic [7:0]        d_last;
    stl_pkg::t_op      d_op [stl_pkg::OP_SLOTS];
    stl_pkg::t_op      w_op [stl_pkg::WORD_OPS];
    logic              w_keep;
    stl_pkg::t_tok     v_k;

    logic              s_acc;
    logic              m_acc;
    logic              m_done;
    logic              brace_mode;
    logic [7:0]        c;
    stl_pkg::t_rec     out_rec;

    assign c          = i_s_tdata;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign o_m_tlast  = (stl_pkg::RES_CNT_BITS'(r_rd) + 1'b1) == r_cnt;
    assign m_done     = m_acc && o_m_tlast;
    assign o_s_tready = (r_cnt == '0) || m_done;
    assign o_m_tvalid = (r_cnt != '0);
    assign brace_mode = (r_mode == stl_pkg::MODE_READY) || (r_mode == stl_pkg::MODE_WORD)
                     || (r_mode == stl_pkg::MODE_VAR);

    // word and variable byte handling, also used for the byte after a lone slash
    always_comb begin
        w_op[0] = stl_pkg::mk_op(stl_pkg::OP_NONE, '0);
        w_op[1] = stl_pkg::mk_op(stl_pkg::OP_NONE, '0);
        w_op[2] = stl_pkg::mk_op(stl_pkg::OP_NONE, '0);
        w_keep  = 1'b0;
        if (stl_pkg::is_nl(c)) begin
            w_op[0] = stl_pkg::mk_op(stl_pkg::OP_TOKEN, '0);
            w_op[1] = stl_pkg::mk_op(stl_pkg::OP_NLTOK, c);
        end else if (stl_pkg::is_ws(c)) begin
            w_op[0] = stl_pkg::mk_op(stl_pkg::OP_TOKEN, '0);
        end else if (c == stl_pkg::CH_LBRACE || c == stl_pkg::CH_RBRACE
                     || c == stl_pkg::CH_COLON) begin
            w_op[0] = stl_pkg::mk_op(stl_pkg::OP_TOKEN, '0);
            w_op[1] = stl_pkg::mk_op(stl_pkg::OP_START, c);
            w_op[2] = stl_pkg::mk_op(stl_pkg::OP_TOKEN, '0);
        end else begin
            w_op[0] = stl_pkg::mk_op(stl_pkg::OP_ADD, c);
            w_keep  = 1'b1;
        end
    end

    // next state and action list
    always_comb begin
        n_mode   = r_mode;
        n_prev   = r_prev;
        n_line   = r_line;
        n_qline  = r_qline;
        n_bline  = r_bline;
        n_depth  = r_depth;
        n_sticky = r_sticky;
        n_sline  = r_sline;
        d_len    = r_len;
        d_first  = r_first;
        d_last   = r_last;
        for (int i = 0; i < stl_pkg::OP_SLOTS; i++) begin
            d_op[i] = stl_pkg::mk_op(stl_pkg::OP_NONE, '0);
        end
        if (i_s_tuser) begin
            if (r_sticky == stl_pkg::ERR_NONE
                && (r_mode == stl_pkg::MODE_WORD || r_mode == stl_pkg::MODE_VAR)) begin
                d_op[0] = stl_pkg::mk_op(stl_pkg::OP_TOKEN, '0);
            end
            n_mode   = stl_pkg::MODE_READY;
            n_prev   = '0;
            n_line   = stl_pkg::t_line'(1);
            n_qline  = '0;
            n_bline  = '0;
            n_depth  = '0;
            n_sticky = stl_pkg::ERR_NONE;
            n_sline  = '0;
        end else if (r_sticky == stl_pkg::ERR_NONE) begin
            if (c == stl_pkg::CH_QUOTE) begin
                n_qline = r_line;
            end
            if (brace_mode && c == stl_pkg::CH_RBRACE && r_depth == '0) begin
                n_sticky = stl_pkg::ERR_UNMATCHED;
                n_sline  = r_line;
            end else begin
                if (brace_mode && c == stl_pkg::CH_LBRACE) begin
                    if (r_depth == '0) begin
                        n_bline = r_line;
                    end
                    if (r_depth != '1) begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (brace_mode && c == stl_pkg::CH_RBRACE) begin
                    n_depth = r_depth - 1'b1;
                end
                unique case (r_mode)
                    stl_pkg::MODE_COMMENT: begin
                        if (stl_pkg::is_nl(c)) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_NLTOK, c);
                            n_mode  = stl_pkg::MODE_READY;
                        end
                    end
                    stl_pkg::MODE_BLOCK: begin
                        if (c == stl_pkg::CH_SLASH && r_prev == stl_pkg::CH_STAR) begin
                            n_mode = stl_pkg::MODE_READY;
                        end
                    end
                    stl_pkg::MODE_SLASH: begin
                        if (c == stl_pkg::CH_SLASH) begin
                            d_len  = '0;
                            n_mode = stl_pkg::MODE_COMMENT;
                        end else if (c == stl_pkg::CH_STAR) begin
                            d_len  = '0;
                            n_mode = stl_pkg::MODE_BLOCK;
                        end else begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_EMIT, stl_pkg::CH_SLASH);
                            d_op[1] = w_op[0];
                            d_op[2] = w_op[1];
                            d_op[3] = w_op[2];
                            n_mode  = w_keep ? stl_pkg::MODE_WORD : stl_pkg::MODE_READY;
                        end
                    end
                    stl_pkg::MODE_WORD, stl_pkg::MODE_VAR: begin
                        d_op[0] = w_op[0];
                        d_op[1] = w_op[1];
                        d_op[2] = w_op[2];
                        if (!w_keep) begin
                            n_mode = stl_pkg::MODE_READY;
                        end
                    end
                    stl_pkg::MODE_QUOTE: begin
                        if (c == stl_pkg::CH_BSLASH) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_NONE, '0);
                        end else if (c == stl_pkg::CH_QUOTE && r_prev == stl_pkg::CH_BSLASH) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_ADD, c);
                        end else if (c == stl_pkg::CH_QUOTE) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_ADD, c);
                            d_op[1] = stl_pkg::mk_op(stl_pkg::OP_TOKEN, '0);
                            n_mode  = stl_pkg::MODE_READY;
                        end else if (r_prev == stl_pkg::CH_BSLASH) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_ADD, stl_pkg::CH_BSLASH);
                            d_op[1] = stl_pkg::mk_op(stl_pkg::OP_ADD, c);
                        end else begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_ADD, c);
                        end
                    end
                    default: begin
                        if (c == stl_pkg::CH_SLASH && r_prev == stl_pkg::CH_SLASH) begin
                            d_len  = '0;
                            n_mode = stl_pkg::MODE_COMMENT;
                        end else if (c == stl_pkg::CH_STAR && r_prev == stl_pkg::CH_SLASH) begin
                            d_len  = '0;
                            n_mode = stl_pkg::MODE_BLOCK;
                        end else if (c == stl_pkg::CH_QUOTE) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_START, c);
                            n_mode  = stl_pkg::MODE_QUOTE;
                        end else if (c == stl_pkg::CH_DOLLAR) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_START, c);
                            n_mode  = stl_pkg::MODE_VAR;
                        end else if (stl_pkg::is_nl(c)) begin
                            d_op[0] = stl_pkg::mk_op(stl_pkg::OP_NLTOK, c);
                        end else if (!stl_pkg::is_ws(c)) begin
                            if (c == stl_pkg::CH_SLASH) begin
                                d_len   = stl_pkg::t_len'(1);
                                d_first = c;
                                d_last  = c;
                                n_mode  = stl_pkg::MODE_SLASH;
                            end else begin
                                d_op[0] = stl_pkg::mk_op(stl_pkg::OP_START, c);
                                n_mode  = stl_pkg::MODE_WORD;
                            end
                        end
                    end
                endcase
                if ((c == stl_pkg::CH_CR || (c == stl_pkg::CH_LF && r_prev != stl_pkg::CH_CR))
                    && r_line != '1) begin
                    n_line = r_line + 1'b1;
                end
                n_prev = c;
            end
        end
    end

    // run the action list into result records
    always_comb begin
        n_len   = d_len;
        n_first = d_first;
        n_last  = d_last;
        n_pnl   = r_pnl;
        n_cnt   = '0;
        v_k     = stl_pkg::TOK_WORD;
        for (int i = 0; i < stl_pkg::RES_MAX; i++) begin
            n_res[i] = '0;
        end
        for (int i = 0; i < stl_pkg::OP_SLOTS; i++) begin
            unique case (d_op[i].code)
                stl_pkg::OP_EMIT: begin
                    n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] = stl_pkg::rec_lex(d_op[i].b);
                    n_cnt = n_cnt + 1'b1;
                end
                stl_pkg::OP_START: begin
                    n_len   = stl_pkg::t_len'(1);
                    n_first = d_op[i].b;
                    n_last  = d_op[i].b;
                    n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] = stl_pkg::rec_lex(d_op[i].b);
                    n_cnt = n_cnt + 1'b1;
                end
                stl_pkg::OP_ADD: begin
                    if (n_len != '1) begin
                        n_len = n_len + 1'b1;
                    end
                    n_last = d_op[i].b;
                    n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] = stl_pkg::rec_lex(d_op[i].b);
                    n_cnt = n_cnt + 1'b1;
                end
                stl_pkg::OP_TOKEN: begin
                    v_k = stl_pkg::classify(n_len, n_first, n_last);
                    if (!(v_k == stl_pkg::TOK_NEWLINE && n_pnl)) begin
                        n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                            stl_pkg::rec_tok(v_k, n_len, r_line);
                        n_cnt = n_cnt + 1'b1;
                        n_pnl = (v_k == stl_pkg::TOK_NEWLINE);
                    end
                end
                stl_pkg::OP_NLTOK: begin
                    if (!n_pnl) begin
                        n_len   = stl_pkg::t_len'(1);
                        n_first = d_op[i].b;
                        n_last  = d_op[i].b;
                        n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] = stl_pkg::rec_lex(d_op[i].b);
                        n_cnt = n_cnt + 1'b1;
                        n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                            stl_pkg::rec_tok(stl_pkg::TOK_NEWLINE, n_len, r_line);
                        n_cnt = n_cnt + 1'b1;
                        n_pnl = 1'b1;
                    end
                end
                default: begin
                    n_cnt = n_cnt;
                end
            endcase
        end
        if (i_s_tuser) begin
            if (r_sticky != stl_pkg::ERR_NONE) begin
                n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                    stl_pkg::rec_end(stl_pkg::ERR_UNMATCHED, r_sline, '0);
            end else if (r_mode == stl_pkg::MODE_QUOTE) begin
                n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                    stl_pkg::rec_end(stl_pkg::ERR_QUOTE, r_qline, '0);
            end else if (r_depth == stl_pkg::t_depth'(1)) begin
                n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                    stl_pkg::rec_end(stl_pkg::ERR_ONE_OPEN, r_bline, r_depth);
            end else if (r_depth > stl_pkg::t_depth'(1)) begin
                n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                    stl_pkg::rec_end(stl_pkg::ERR_MANY_OPEN, '0, r_depth);
            end else begin
                n_res[n_cnt[stl_pkg::RES_IDX_BITS-1:0]] =
                    stl_pkg::rec_end(stl_pkg::ERR_NONE, '0, '0);
            end
            n_cnt   = n_cnt + 1'b1;
            n_len   = '0;
            n_first = '0;
            n_last  = '0;
            n_pnl   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stl_pkg::MODE_READY;
            r_prev   <= '0;
            r_line   <= stl_pkg::t_line'(1);
            r_qline  <= '0;
            r_bline  <= '0;
            r_depth  <= '0;
            r_len    <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_pnl    <= 1'b0;
            r_sticky <= stl_pkg::ERR_NONE;
            r_sline  <= '0;
            r_cnt    <= '0;
            r_rd     <= '0;
        end else if (s_acc) begin
            r_mode   <= n_mode;
            r_prev   <= n_prev;
            r_line   <= n_line;
            r_qline  <= n_qline;
            r_bline  <= n_bline;
            r_depth  <= n_depth;
            r_len    <= n_len;
            r_first  <= n_first;
            r_last   <= n_last;
            r_pnl    <= n_pnl;
            r_sticky <= n_sticky;
            r_sline  <= n_sline;
            r_cnt    <= n_cnt;
            r_rd     <= '0;
        end else if (m_done) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (m_acc) begin
            r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_res <= n_res;
        end
    end

    assign out_rec   = r_res[r_rd];
    assign o_m_tuser = out_rec.kind;
    assign o_m_tdata = stl_pkg::M_DATA_BITS'({out_rec.open, out_rec.err_line, out_rec.err,
                                              out_rec.line, out_rec.len, out_rec.tok,
                                              out_rec.lex});

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= stl_pkg::RES_CNT_BITS'(stl_pkg::RES_MAX))
        else $error("result count above buffer depth");

    a_rd_below_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (stl_pkg::RES_CNT_BITS'(r_rd) < r_cnt))
        else $error("read pointer past last result");

    a_sticky_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_s_tuser && r_sticky != stl_pkg::ERR_NONE) |=> (r_cnt == '0))
        else $error("text byte produced records after sticky error");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser) |=> (r_mode == stl_pkg::MODE_READY && r_depth == '0
                                  && r_sticky == stl_pkg::ERR_NONE && r_cnt != '0))
        else $error("finish did not reset lexer or emit end record");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == stl_pkg::REC_END) |-> o_m_tlast)
        else $error("end record not last of its run");
`endif

endmodule

`default_nettype wire

// File: sim/script_token_lexer_tb.sv
`timescale 1ns / 1ps

module script_token_lexer_tb;

    localparam logic ITEM_TEXT   = 1'b0;
    localparam logic ITEM_FINISH = 1'b1;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASE_ITEMS     = 130;

    localparam int LEX_LSB   = 0;
    localparam int TOK_LSB   = 8;
    localparam int LEN_LSB   = TOK_LSB + 3;
    localparam int LINE_LSB  = LEN_LSB + stl_pkg::LENGTH_BITS;
    localparam int ERR_LSB   = LINE_LSB + stl_pkg::LINE_BITS;
    localparam int ELINE_LSB = ERR_LSB + 3;
    localparam int OPEN_LSB  = ELINE_LSB + stl_pkg::LINE_BITS;
    localparam int FILL_LSB  = OPEN_LSB + stl_pkg::DEPTH_BITS;

    typedef struct packed {
        stl_pkg::t_rec_kind kind;
        logic [7:0]         lex;
        stl_pkg::t_tok      tok;
        stl_pkg::t_len      len;
        stl_pkg::t_line     line;
        stl_pkg::t_err      err;
        stl_pkg::t_line     err_line;
        stl_pkg::t_depth    depth;
        logic               run_end;
    } t_lex_record;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [stl_pkg::M_DATA_BITS-1:0] o_m_tdata;
    logic [1:0]                      o_m_tuser;
    logic                            o_m_tlast;

    script_token_lexer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Lexer state as predicted from the accepted transactions
    stl_pkg::t_mode   lx_mode;
    logic [7:0]       lx_prev;
    stl_pkg::t_line   lx_line;
    stl_pkg::t_line   lx_quote_line;
    stl_pkg::t_line   lx_brace_line;
    stl_pkg::t_depth  lx_depth;
    stl_pkg::t_len    lx_len;
    logic [7:0]       lx_first;
    logic [7:0]       lx_final;
    logic             lx_prev_nl;
    stl_pkg::t_err    lx_err;
    stl_pkg::t_line   lx_err_line;

    t_lex_record item_recs[$];
    t_lex_record expected_records[$];

    int send_idle_pct = 7;
    int recv_idle_pct = 70;
    int useful_items  = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic is_eol(logic [7:0] c);
        return c == stl_pkg::CH_CR || c == stl_pkg::CH_LF;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == stl_pkg::CH_SPACE || c == stl_pkg::CH_TAB;
    endfunction

    task automatic clear_lexer();
        lx_mode       = stl_pkg::MODE_READY;
        lx_prev       = '0;
        lx_line       = stl_pkg::t_line'(1);
        lx_quote_line = '0;
        lx_brace_line = '0;
        lx_depth      = '0;
        lx_len        = '0;
        lx_first      = '0;
        lx_final      = '0;
        lx_prev_nl    = 1'b0;
        lx_err        = stl_pkg::ERR_NONE;
        lx_err_line   = '0;
    endtask

    task automatic emit_lexeme(logic [7:0] c);
        t_lex_record r;
        r      = '0;
        r.kind = stl_pkg::REC_LEXEME;
        r.lex  = c;
        item_recs.insert(item_recs.size(), r);
    endtask

    task automatic lexeme_start(logic [7:0] c);
        lx_len   = stl_pkg::t_len'(1);
        lx_first = c;
        lx_final = c;
        emit_lexeme(c);
    endtask

    task automatic lexeme_append(logic [7:0] c);
        if (lx_len != '1) begin
            lx_len = lx_len + 1'b1;
        end
        lx_final = c;
        emit_lexeme(c);
    endtask

    function automatic stl_pkg::t_tok token_class();
        logic single;
        single = (lx_len == stl_pkg::t_len'(1));
        if (single && is_eol(lx_first)) return stl_pkg::TOK_NEWLINE;
        if (single && lx_first == stl_pkg::CH_LBRACE) return stl_pkg::TOK_OPEN;
        if (single && lx_first == stl_pkg::CH_RBRACE) return stl_pkg::TOK_CLOSE;
        if (single && lx_first == stl_pkg::CH_COLON) return stl_pkg::TOK_COLON;
        if (lx_len > stl_pkg::t_len'(1) && lx_first == stl_pkg::CH_DOLLAR) begin
            return stl_pkg::TOK_VAR;
        end
        if (lx_len > stl_pkg::t_len'(1) && lx_first == stl_pkg::CH_QUOTE
            && lx_final == stl_pkg::CH_QUOTE) begin
            return stl_pkg::TOK_QUOTED;
        end
        return stl_pkg::TOK_WORD;
    endfunction

    task automatic token_done();
        t_lex_record   r;
        stl_pkg::t_tok k;
        k = token_class();
        if (k == stl_pkg::TOK_NEWLINE && lx_prev_nl) begin
            return;
        end
        r      = '0;
        r.kind = stl_pkg::REC_TOKEN;
        r.tok  = k;
        r.len  = lx_len;
        r.line = lx_line;
        item_recs.insert(item_recs.size(), r);
        lx_prev_nl = (k == stl_pkg::TOK_NEWLINE);
    endtask

    task automatic newline_token(logic [7:0] c);
        if (lx_prev_nl) begin
            return;
        end
        lexeme_start(c);
        token_done();
    endtask

    task automatic word_byte(logic [7:0] c);
        if (is_eol(c)) begin
            token_done();
            newline_token(c);
            lx_mode = stl_pkg::MODE_READY;
        end else if (is_blank(c)) begin
            token_done();
            lx_mode = stl_pkg::MODE_READY;
        end else if (c == stl_pkg::CH_LBRACE || c == stl_pkg::CH_RBRACE
                     || c == stl_pkg::CH_COLON) begin
            token_done();
            lexeme_start(c);
            token_done();
            lx_mode = stl_pkg::MODE_READY;
        end else begin
            lexeme_append(c);
        end
    endtask

    task automatic ready_byte(logic [7:0] c);
        if (c == stl_pkg::CH_SLASH && lx_prev == stl_pkg::CH_SLASH) begin
            lx_len  = '0;
            lx_mode = stl_pkg::MODE_COMMENT;
        end else if (c == stl_pkg::CH_STAR && lx_prev == stl_pkg::CH_SLASH) begin
            lx_len  = '0;
            lx_mode = stl_pkg::MODE_BLOCK;
        end else if (c == stl_pkg::CH_QUOTE) begin
            lexeme_start(c);
            lx_mode = stl_pkg::MODE_QUOTE;
        end else if (c == stl_pkg::CH_DOLLAR) begin
            lexeme_start(c);
            lx_mode = stl_pkg::MODE_VAR;
        end else if (is_eol(c)) begin
            newline_token(c);
        end else if (c == stl_pkg::CH_SLASH) begin
            // hold the slash until the next byte decides
            lx_len   = stl_pkg::t_len'(1);
            lx_first = c;
            lx_final = c;
            lx_mode  = stl_pkg::MODE_SLASH;
        end else if (!is_blank(c)) begin
            lexeme_start(c);
            lx_mode = stl_pkg::MODE_WORD;
        end
    endtask

    task automatic quote_byte(logic [7:0] c);
        if (c == stl_pkg::CH_BSLASH) begin
            return;
        end
        if (c == stl_pkg::CH_QUOTE && lx_prev == stl_pkg::CH_BSLASH) begin
            lexeme_append(c);
        end else if (c == stl_pkg::CH_QUOTE) begin
            lexeme_append(c);
            token_done();
            lx_mode = stl_pkg::MODE_READY;
        end else begin
            if (lx_prev == stl_pkg::CH_BSLASH) begin
                lexeme_append(stl_pkg::CH_BSLASH);
            end
            lexeme_append(c);
        end
    endtask

    task automatic lex_text_byte(logic [7:0] c);
        if (c == stl_pkg::CH_QUOTE) begin
            lx_quote_line = lx_line;
        end
        if (lx_mode == stl_pkg::MODE_READY || lx_mode == stl_pkg::MODE_WORD
            || lx_mode == stl_pkg::MODE_VAR) begin
            if (c == stl_pkg::CH_LBRACE) begin
                if (lx_depth == '0) begin
                    lx_brace_line = lx_line;
                end
                if (lx_depth != '1) begin
                    lx_depth = lx_depth + 1'b1;
                end
            end else if (c == stl_pkg::CH_RBRACE) begin
                if (lx_depth == '0) begin
                    lx_err      = stl_pkg::ERR_UNMATCHED;
                    lx_err_line = lx_line;
                    return;
                end
                lx_depth = lx_depth - 1'b1;
            end
        end
        case (lx_mode)
            stl_pkg::MODE_COMMENT: begin
                if (is_eol(c)) begin
                    newline_token(c);
                    lx_mode = stl_pkg::MODE_READY;
                end
            end
            stl_pkg::MODE_BLOCK: begin
                if (c == stl_pkg::CH_SLASH && lx_prev == stl_pkg::CH_STAR) begin
                    lx_mode = stl_pkg::MODE_READY;
                end
            end
            stl_pkg::MODE_SLASH: begin
                if (c == stl_pkg::CH_SLASH) begin
                    lx_len  = '0;
                    lx_mode = stl_pkg::MODE_COMMENT;
                end else if (c == stl_pkg::CH_STAR) begin
                    lx_len  = '0;
                    lx_mode = stl_pkg::MODE_BLOCK;
                end else begin
                    emit_lexeme(stl_pkg::CH_SLASH);
                    lx_mode = stl_pkg::MODE_WORD;
                    word_byte(c);
                end
            end
            stl_pkg::MODE_WORD, stl_pkg::MODE_VAR: begin
                word_byte(c);
            end
            stl_pkg::MODE_QUOTE: begin
                quote_byte(c);
            end
            default: begin
                ready_byte(c);
            end
        endcase
        if (c == stl_pkg::CH_CR || (c == stl_pkg::CH_LF && lx_prev != stl_pkg::CH_CR)) begin
            if (lx_line != '1) begin
                lx_line = lx_line + 1'b1;
            end
        end
        lx_prev = c;
    endtask

    task automatic lex_finish();
        t_lex_record r;
        r      = '0;
        r.kind = stl_pkg::REC_END;
        if (lx_err != stl_pkg::ERR_NONE) begin
            r.err      = stl_pkg::ERR_UNMATCHED;
            r.err_line = lx_err_line;
        end else begin
            if (lx_mode == stl_pkg::MODE_WORD || lx_mode == stl_pkg::MODE_VAR) begin
                token_done();
            end
            if (lx_mode == stl_pkg::MODE_QUOTE) begin
                r.err      = stl_pkg::ERR_QUOTE;
                r.err_line = lx_quote_line;
            end else if (lx_depth == stl_pkg::t_depth'(1)) begin
                r.err      = stl_pkg::ERR_ONE_OPEN;
                r.err_line = lx_brace_line;
                r.depth    = stl_pkg::t_depth'(1);
            end else if (lx_depth > stl_pkg::t_depth'(1)) begin
                r.err   = stl_pkg::ERR_MANY_OPEN;
                r.depth = lx_depth;
            end
        end
        item_recs.insert(item_recs.size(), r);
        clear_lexer();
    endtask

    task automatic predict_item(logic op, logic [7:0] c);
        item_recs.delete();
        if (op == ITEM_FINISH) begin
            lex_finish();
        end else if (lx_err == stl_pkg::ERR_NONE) begin
            lex_text_byte(c);
        end
        if (item_recs.size() > 0) begin
            item_recs[item_recs.size() - 1].run_end = 1'b1;
        end
        foreach (item_recs[i]) begin
            expected_records.insert(expected_records.size(), item_recs[i]);
        end
    endtask

    task automatic send_item(logic op, logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        if (op == ITEM_FINISH || lx_err == stl_pkg::ERR_NONE) begin
            useful_items++;
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        predict_item(op, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(ITEM_TEXT, s[i]);
        end
    endtask

    task automatic send_finish();
        send_item(ITEM_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_records.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] word_char();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(255, 128));
        end
        return 8'(8'h61 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(11))
            0:       return stl_pkg::CH_SLASH;
            1:       return stl_pkg::CH_STAR;
            2:       return stl_pkg::CH_QUOTE;
            3:       return stl_pkg::CH_BSLASH;
            4:       return stl_pkg::CH_DOLLAR;
            5:       return stl_pkg::CH_LBRACE;
            6:       return stl_pkg::CH_RBRACE;
            7:       return stl_pkg::CH_COLON;
            8:       return stl_pkg::CH_CR;
            9:       return stl_pkg::CH_LF;
            10:      return stl_pkg::CH_SPACE;
            default: return stl_pkg::CH_TAB;
        endcase
    endfunction

    task automatic send_script();
        int pieces;
        int depth;
        pieces = $urandom_range(12, 1);
        depth  = 0;
        repeat (pieces) begin
            case ($urandom_range(11))
                0: begin
                    repeat ($urandom_range(6, 1)) send_item(ITEM_TEXT, word_char());
                end
                1: begin
                    send_item(ITEM_TEXT, stl_pkg::CH_DOLLAR);
                    repeat ($urandom_range(4)) send_item(ITEM_TEXT, word_char());
                end
                2: begin
                    send_item(ITEM_TEXT, stl_pkg::CH_QUOTE);
                    repeat ($urandom_range(5)) begin
                        case ($urandom_range(3))
                            0: begin
                                send_item(ITEM_TEXT, stl_pkg::CH_BSLASH);
                                send_item(ITEM_TEXT, stl_pkg::CH_QUOTE);
                            end
                            1: begin
                                send_item(ITEM_TEXT, stl_pkg::CH_BSLASH);
                                send_item(ITEM_TEXT, word_char());
                            end
                            2: send_item(ITEM_TEXT, special_char());
                            default: send_item(ITEM_TEXT, word_char());
                        endcase
                    end
                    if ($urandom_range(9) != 0) begin
                        send_item(ITEM_TEXT, stl_pkg::CH_QUOTE);
                    end
                end
                3: begin
                    send_item(ITEM_TEXT, stl_pkg::CH_LBRACE);
                    depth++;
                end
                4: begin
                    if (depth > 0 || $urandom_range(19) == 0) begin
                        send_item(ITEM_TEXT, stl_pkg::CH_RBRACE);
                        if (depth > 0) begin
                            depth--;
                        end
                    end
                end
                5: send_item(ITEM_TEXT, stl_pkg::CH_COLON);
                6: begin
                    case ($urandom_range(2))
                        0: send_item(ITEM_TEXT, stl_pkg::CH_CR);
                        1: send_item(ITEM_TEXT, stl_pkg::CH_LF);
                        default: begin
                            send_item(ITEM_TEXT, stl_pkg::CH_CR);
                            send_item(ITEM_TEXT, stl_pkg::CH_LF);
                        end
                    endcase
                end
                7: begin
                    repeat ($urandom_range(2, 1)) begin
                        send_item(ITEM_TEXT,
                                  $urandom_range(1) ? stl_pkg::CH_SPACE : stl_pkg::CH_TAB);
                    end
                end
                8: begin
                    send_item(ITEM_TEXT, stl_pkg::CH_SLASH);
                    send_item(ITEM_TEXT, stl_pkg::CH_SLASH);
                    repeat ($urandom_range(4)) begin
                        send_item(ITEM_TEXT, $urandom_range(2) ? word_char() : special_char());
                    end
                    send_item(ITEM_TEXT, stl_pkg::CH_LF);
                end
                9: begin
                    send_item(ITEM_TEXT, stl_pkg::CH_SLASH);
                    send_item(ITEM_TEXT, stl_pkg::CH_STAR);
                    repeat ($urandom_range(4)) begin
                        send_item(ITEM_TEXT, $urandom_range(1) ? word_char() : special_char());
                    end
                    if ($urandom_range(9) != 0) begin
                        send_item(ITEM_TEXT, stl_pkg::CH_STAR);
                        send_item(ITEM_TEXT, stl_pkg::CH_SLASH);
                    end
                end
                10: send_item(ITEM_TEXT, stl_pkg::CH_SLASH);
                default: send_item(ITEM_TEXT, 8'($urandom_range(255)));
            endcase
        end
        // close what is still open most of the time
        if ($urandom_range(9) < 7) begin
            repeat (depth) send_item(ITEM_TEXT, stl_pkg::CH_RBRACE);
        end
        send_finish();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(10, 1)) begin
            send_item(ITEM_TEXT, $urandom_range(1) ? 8'($urandom_range(255)) : special_char());
        end
        send_finish();
    endtask

    task automatic test_tokens_and_comments();
        send_text("{$v:/**//c\n\n/a /{\"\\\"\\n\"}");
        send_item(ITEM_TEXT, 8'hFF);
        send_item(ITEM_TEXT, 8'h00);
        send_finish();
    endtask

    task automatic test_line_breaks_and_open_quote();
        send_item(ITEM_TEXT, stl_pkg::CH_CR);
        send_item(ITEM_TEXT, stl_pkg::CH_LF);
        send_text("\t\"x");
        send_finish();
    endtask

    task automatic test_brace_errors();
        send_text("a}b");
        send_finish();
        send_text("{");
        send_finish();
        send_text("{{/");
        send_finish();
    endtask

    task automatic test_random_scripts(int target);
        int first_count;
        first_count = useful_items;
        while (useful_items - first_count < target) begin
            if ($urandom_range(9) < 8) begin
                send_script();
            end else begin
                send_noise();
            end
            if ($urandom_range(7) == 0) begin
                hold_until_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_records
        t_lex_record want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected record, expected none, actual kind %0d data 0x%0h",
                         $time, o_m_tuser, o_m_tdata);
                fail_count++;
            end else begin
                want = expected_records.pop_front();
                check_field("record_kind", want.kind, o_m_tuser);
                check_field("lexeme_byte", want.lex, o_m_tdata[LEX_LSB +: 8]);
                check_field("token_kind", want.tok, o_m_tdata[TOK_LSB +: 3]);
                check_field("token_length", want.len,
                            o_m_tdata[LEN_LSB +: stl_pkg::LENGTH_BITS]);
                check_field("token_line", want.line,
                            o_m_tdata[LINE_LSB +: stl_pkg::LINE_BITS]);
                check_field("error_code", want.err, o_m_tdata[ERR_LSB +: 3]);
                check_field("error_line", want.err_line,
                            o_m_tdata[ELINE_LSB +: stl_pkg::LINE_BITS]);
                check_field("open_braces", want.depth,
                            o_m_tdata[OPEN_LSB +: stl_pkg::DEPTH_BITS]);
                check_field("zero_fill", 0, o_m_tdata[stl_pkg::M_DATA_BITS-1:FILL_LSB]);
                check_field("last_of_run", want.run_end, o_m_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("[script_token_lexer] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= ITEM_TEXT;
        i_s_tdata  <= '0;
        clear_lexer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tokens_and_comments();
        test_line_breaks_and_open_quote();
        test_brace_errors();
        test_random_scripts(PHASE_ITEMS);

        send_idle_pct = 70;
        recv_idle_pct = 7;
        test_random_scripts(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_scripts(PHASE_ITEMS);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[script_token_lexer] OK");
        end else begin
            $display("[script_token_lexer] ERROR");
        end
        $finish;
    end

endmodule
